>>> rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants of the look-at view matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic signed [32:0] d_t;

  typedef struct packed {
    q_t [2:0] eye;
    d_t [2:0] dir;
    q_t [2:0] up;
  } item_t;

  typedef struct packed {
    logic [1:0] idx;
    q_t [3:0]   row;
    logic       last;
  } col_t;

  localparam logic [1:0]  COL_LAST   = 2'd3;
  localparam logic [16:0] MINLEN_RST = 17'd66;

endpackage

>>> rtl/look_at_view_matrix.sv
// an item stays in the engine longest when both vectors normalize; each one
// that falls below min_length skips its square root and divide
// each normalization runs a 32-step square root and a 32-step divide; one
// item is worked at a time, the next waits in a two-entry queue
// reset (synchronous, rst_n low) empties both queues and sets min_length to 66
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point camera view matrix, emitted as four column words.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_column_index,
  output logic signed [31:0] out_row0_value,
  output logic signed [31:0] out_row1_value,
  output logic signed [31:0] out_row2_value,
  output logic signed [31:0] out_row3_value,
  output logic               out_is_last,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_data
);
  import lav_pkg::*;

  logic [16:0] min_length_r;
  logic        fq_valid;
  item_t       fq_item;
  logic        eng_pop;
  logic        col_push;
  logic        col_full;
  col_t        eng_col;
  col_t        oq_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MINLEN_RST;
    end else if (cfg_we) begin
      min_length_r <= cfg_data;
    end
  end

  lav_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .eye_x      (in_eye_x),
    .eye_y      (in_eye_y),
    .eye_z      (in_eye_z),
    .target_x   (in_target_x),
    .target_y   (in_target_y),
    .target_z   (in_target_z),
    .up_x       (in_up_x),
    .up_y       (in_up_y),
    .up_z       (in_up_z),
    .item_valid (fq_valid),
    .item       (fq_item),
    .item_pop   (eng_pop)
  );

  lav_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_length (min_length_r),
    .item_valid (fq_valid),
    .item       (fq_item),
    .item_pop   (eng_pop),
    .col_push   (col_push),
    .col_full   (col_full),
    .col        (eng_col)
  );

  lav_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_push  (col_push),
    .col_full  (col_full),
    .col_in    (eng_col),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .col_out   (oq_col)
  );

  assign out_column_index = oq_col.idx;
  assign out_row0_value   = oq_col.row[0];
  assign out_row1_value   = oq_col.row[1];
  assign out_row2_value   = oq_col.row[2];
  assign out_row3_value   = oq_col.row[3];
  assign out_is_last      = oq_col.last;

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_is_last == (out_column_index == COL_LAST)))
    else $error("last flag does not match column index");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    eng_pop |-> fq_valid)
    else $error("engine took a word from an empty input queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

>>> rtl/lav_front.sv
// ----------------------------------------------------------------------------
// lav_front
// Input side: takes words, forms target - eye, holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lav_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  lav_pkg::q_t   eye_x,
  input  lav_pkg::q_t   eye_y,
  input  lav_pkg::q_t   eye_z,
  input  lav_pkg::q_t   target_x,
  input  lav_pkg::q_t   target_y,
  input  lav_pkg::q_t   target_z,
  input  lav_pkg::q_t   up_x,
  input  lav_pkg::q_t   up_y,
  input  lav_pkg::q_t   up_z,
  output logic          item_valid,
  output lav_pkg::item_t item,
  input  logic          item_pop
);
  import lav_pkg::*;

  item_t      mem_r [2];
  item_t      wr_item;
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_pop && item_valid;
  assign item       = mem_r[rd_r];

  always_comb begin
    wr_item.eye[0] = eye_x;
    wr_item.eye[1] = eye_y;
    wr_item.eye[2] = eye_z;
    wr_item.up[0]  = up_x;
    wr_item.up[1]  = up_y;
    wr_item.up[2]  = up_z;
    wr_item.dir[0] = 33'(target_x) - 33'(eye_x);
    wr_item.dir[1] = 33'(target_y) - 33'(eye_y);
    wr_item.dir[2] = 33'(target_z) - 33'(eye_z);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/lav_back.sv
// ----------------------------------------------------------------------------
// lav_back
// Engine: two normalizations, two cross products and three dot products on
// one shared multiplier, bit-serial square root and three divide lanes.
// ----------------------------------------------------------------------------
module lav_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [16:0]    min_length,
  input  logic           item_valid,
  input  lav_pkg::item_t item,
  output logic           item_pop,
  output logic           col_push,
  input  logic           col_full,
  output lav_pkg::col_t  col
);
  import lav_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NPREP  = 4'd1;
  localparam logic [3:0] S_NSQ    = 4'd2;
  localparam logic [3:0] S_NSHIFT = 4'd3;
  localparam logic [3:0] S_NSUM   = 4'd4;
  localparam logic [3:0] S_NSQRT  = 4'd5;
  localparam logic [3:0] S_NDIVP  = 4'd6;
  localparam logic [3:0] S_NDIV   = 4'd7;
  localparam logic [3:0] S_NFIN   = 4'd8;
  localparam logic [3:0] S_CROSS  = 4'd9;
  localparam logic [3:0] S_DOT    = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

  logic [3:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic       mode_r, mode_nxt;
  logic       cross_r, cross_nxt;

  q_t                 eye_r [3];
  q_t                 up_r  [3];
  q_t                 f_r   [3];
  q_t                 s_r   [3];
  q_t                 u_r   [3];
  q_t                 d_r   [3];
  logic signed [63:0] vec_r [3];
  logic [63:0]        m_r   [3];
  logic               neg_r [3];
  logic [30:0]        qm_r  [3];
  logic               small_r;
  logic signed [65:0] p_r;
  logic signed [65:0] acc_r;
  logic signed [65:0] tmp_r;
  logic signed [65:0] dsum_r [3];
  logic [63:0]        sq_n_r;
  logic [63:0]        sq_res_r;
  logic [31:0]        rem_r [3];
  logic [31:0]        nlo_r [3];
  logic [31:0]        quo_r [3];

  logic signed [32:0] mul_a, mul_b;
  logic [63:0]        orv;
  logic               nzero;
  logic [6:0]         sh;
  logic               rsh_go, lsh_go;
  logic [63:0]        sbit, st;
  logic               sge;
  logic [32:0]        dtry [3];
  logic               dge  [3];
  logic [31:0]        drem [3];
  logic [63:0]        mg   [3];
  logic [63:0]        qv   [3];
  logic [63:0]        nnum [3];
  q_t                 ca   [3];
  q_t                 cb   [3];
  logic [3:0]         itag, ptag;
  logic [5:0]         jstep;
  logic signed [65:0] diff;

  function automatic q_t rnd_sat(input logic signed [65:0] x, input logic flip);
    logic [65:0] mgx;
    logic [65:0] rq;
    logic        ng;
    q_t          res;
    begin
      mgx = x[65] ? 66'(-x) : 66'(x);
      rq  = (mgx + 66'(HALF)) >> FRAC_BITS;
      ng  = x[65] ^ flip;
      if (!ng) begin
        res = (rq > 66'h7FFFFFFF) ? 32'sh7FFFFFFF : rq[31:0];
      end else begin
        res = (rq > 66'h80000000) ? 32'sh80000000 : -rq[31:0];
      end
      rnd_sat = res;
    end
  endfunction

  // {group, element} of the dot product issued at step k
  function automatic logic [3:0] dot_tag(input logic [5:0] k);
    logic [3:0] t;
    begin
      unique case (k)
        6'd0:    t = {2'd0, 2'd0};
        6'd1:    t = {2'd0, 2'd1};
        6'd2:    t = {2'd0, 2'd2};
        6'd3:    t = {2'd1, 2'd0};
        6'd4:    t = {2'd1, 2'd1};
        6'd5:    t = {2'd1, 2'd2};
        6'd6:    t = {2'd2, 2'd0};
        6'd7:    t = {2'd2, 2'd1};
        6'd8:    t = {2'd2, 2'd2};
        default: t = 4'd0;
      endcase
      dot_tag = t;
    end
  endfunction

  assign orv   = m_r[0] | m_r[1] | m_r[2];
  assign nzero = (orv == 64'd0) || (small_r && (acc_r[63:0] < p_r[63:0]));
  assign jstep = step_r - 6'd1;
  assign itag  = dot_tag(step_r);
  assign ptag  = dot_tag(jstep);
  assign diff  = tmp_r - p_r;

  always_comb begin
    unique case (step_r[2:0])
      3'd0:    sh = 7'd32;
      3'd1:    sh = 7'd16;
      3'd2:    sh = 7'd8;
      3'd3:    sh = 7'd4;
      3'd4:    sh = 7'd2;
      default: sh = 7'd1;
    endcase
    rsh_go = (orv >> (7'd30 + sh)) != 64'd0;
    lsh_go = (sh != 7'd32) && ((orv >> (7'd31 - sh)) == 64'd0);
  end

  always_comb begin
    sbit = 64'd1 << (7'd62 - {step_r, 1'b0});
    st   = sq_res_r + sbit;
    sge  = sq_n_r >= st;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dtry[i] = {rem_r[i], nlo_r[i][31]};
      dge[i]  = dtry[i] >= {1'b0, sq_res_r[31:0]};
      drem[i] = dge[i] ? 32'(dtry[i] - {1'b0, sq_res_r[31:0]}) : dtry[i][31:0];
      mg[i]   = vec_r[i][63] ? 64'(-vec_r[i]) : 64'(vec_r[i]);
      qv[i]   = mode_r ? ((mg[i] + HALF) >> FRAC_BITS) : mg[i];
      nnum[i] = ({33'd0, m_r[i][30:0]} << FRAC_BITS) + {33'd0, sq_res_r[31:1]};
      ca[i]   = cross_r ? s_r[i] : f_r[i];
      cb[i]   = cross_r ? f_r[i] : up_r[i];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_NSQ: begin
        unique case (step_r)
          6'd0:    begin mul_a = {2'b0, qm_r[0]}; mul_b = {2'b0, qm_r[0]}; end
          6'd1:    begin mul_a = {2'b0, qm_r[1]}; mul_b = {2'b0, qm_r[1]}; end
          6'd2:    begin mul_a = {2'b0, qm_r[2]}; mul_b = {2'b0, qm_r[2]}; end
          6'd3:    begin mul_a = {16'b0, min_length}; mul_b = {16'b0, min_length}; end
          default: ;
        endcase
      end
      S_NSUM: begin
        unique case (step_r)
          6'd0:    begin mul_a = {2'b0, m_r[0][30:0]}; mul_b = {2'b0, m_r[0][30:0]}; end
          6'd1:    begin mul_a = {2'b0, m_r[1][30:0]}; mul_b = {2'b0, m_r[1][30:0]}; end
          6'd2:    begin mul_a = {2'b0, m_r[2][30:0]}; mul_b = {2'b0, m_r[2][30:0]}; end
          default: ;
        endcase
      end
      S_CROSS: begin
        unique case (step_r)
          6'd0:    begin mul_a = 33'(ca[1]); mul_b = 33'(cb[2]); end
          6'd1:    begin mul_a = 33'(ca[2]); mul_b = 33'(cb[1]); end
          6'd2:    begin mul_a = 33'(ca[2]); mul_b = 33'(cb[0]); end
          6'd3:    begin mul_a = 33'(ca[0]); mul_b = 33'(cb[2]); end
          6'd4:    begin mul_a = 33'(ca[0]); mul_b = 33'(cb[1]); end
          6'd5:    begin mul_a = 33'(ca[1]); mul_b = 33'(cb[0]); end
          default: ;
        endcase
      end
      S_DOT: begin
        if (step_r <= 6'd8) begin
          unique case (itag[3:2])
            2'd0:    mul_a = 33'(s_r[itag[1:0]]);
            2'd1:    mul_a = 33'(u_r[itag[1:0]]);
            default: mul_a = 33'(f_r[itag[1:0]]);
          endcase
          mul_b = 33'(eye_r[itag[1:0]]);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 6'd1;
    mode_nxt  = mode_r;
    cross_nxt = cross_r;
    item_pop  = 1'b0;
    col_push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (item_valid) begin
          item_pop  = 1'b1;
          mode_nxt  = 1'b0;
          state_nxt = S_NPREP;
        end
      end
      S_NPREP: begin
        step_nxt  = '0;
        state_nxt = S_NSQ;
      end
      S_NSQ: begin
        if (step_r == 6'd4) begin
          step_nxt = '0;
          if (nzero) begin
            state_nxt = S_CROSS;
            cross_nxt = mode_r;
          end else begin
            state_nxt = S_NSHIFT;
          end
        end
      end
      S_NSHIFT: begin
        if (step_r == 6'd5) begin
          step_nxt  = '0;
          state_nxt = S_NSUM;
        end
      end
      S_NSUM: begin
        if (step_r == 6'd3) begin
          step_nxt  = '0;
          state_nxt = S_NSQRT;
        end
      end
      S_NSQRT: begin
        if (step_r == 6'd31) begin
          step_nxt  = '0;
          state_nxt = S_NDIVP;
        end
      end
      S_NDIVP: begin
        step_nxt  = '0;
        state_nxt = S_NDIV;
      end
      S_NDIV: begin
        if (step_r == 6'd31) begin
          step_nxt  = '0;
          state_nxt = S_NFIN;
        end
      end
      S_NFIN: begin
        step_nxt  = '0;
        state_nxt = S_CROSS;
        cross_nxt = mode_r;
      end
      S_CROSS: begin
        if (step_r == 6'd6) begin
          step_nxt = '0;
          if (cross_r) begin
            state_nxt = S_DOT;
          end else begin
            mode_nxt  = 1'b1;
            state_nxt = S_NPREP;
          end
        end
      end
      S_DOT: begin
        if (step_r == 6'd10) begin
          step_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        col_push = 1'b1;
        step_nxt = step_r;
        if (!col_full) begin
          step_nxt = step_r + 6'd1;
          if (step_r == 6'd3) begin
            step_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        step_nxt  = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      mode_r  <= 1'b0;
      cross_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      mode_r  <= mode_nxt;
      cross_r <= cross_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          eye_r[i] <= item.eye[i];
          up_r[i]  <= item.up[i];
          vec_r[i] <= 64'($signed(item.dir[i]));
        end
      end
      S_NPREP: begin
        for (int i = 0; i < 3; i++) begin
          m_r[i]   <= mg[i];
          neg_r[i] <= vec_r[i][63];
          qm_r[i]  <= (qv[i][63:31] == 33'd0) ? qv[i][30:0] : 31'd0;
        end
        small_r <= (qv[0][63:31] == 33'd0) && (qv[1][63:31] == 33'd0)
                   && (qv[2][63:31] == 33'd0);
        acc_r   <= '0;
      end
      S_NSQ: begin
        if (step_r != 6'd0 && step_r != 6'd4) begin
          acc_r <= acc_r + p_r;
        end
        if (step_r == 6'd4 && nzero) begin
          for (int i = 0; i < 3; i++) begin
            if (mode_r) begin
              s_r[i] <= '0;
            end else begin
              f_r[i] <= '0;
            end
          end
        end
      end
      S_NSHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (rsh_go) begin
            m_r[i] <= m_r[i] >> sh;
          end else if (lsh_go) begin
            m_r[i] <= m_r[i] << sh;
          end
        end
        acc_r <= '0;
      end
      S_NSUM: begin
        if (step_r != 6'd0) begin
          acc_r <= acc_r + p_r;
        end
        if (step_r == 6'd3) begin
          sq_n_r   <= 64'(acc_r + p_r);
          sq_res_r <= '0;
        end
      end
      S_NSQRT: begin
        if (sge) begin
          sq_n_r   <= sq_n_r - st;
          sq_res_r <= (sq_res_r >> 1) + sbit;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
      end
      S_NDIVP: begin
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= nnum[i][63:32];
          nlo_r[i] <= nnum[i][31:0];
          quo_r[i] <= '0;
        end
      end
      S_NDIV: begin
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= drem[i];
          nlo_r[i] <= {nlo_r[i][30:0], 1'b0};
          quo_r[i] <= {quo_r[i][30:0], dge[i]};
        end
      end
      S_NFIN: begin
        for (int i = 0; i < 3; i++) begin
          if (mode_r) begin
            s_r[i] <= neg_r[i] ? -quo_r[i] : quo_r[i];
          end else begin
            f_r[i] <= neg_r[i] ? -quo_r[i] : quo_r[i];
          end
        end
      end
      S_CROSS: begin
        if (step_r != 6'd0) begin
          if (!jstep[0]) begin
            tmp_r <= p_r;
          end else if (cross_r) begin
            u_r[jstep[2:1]] <= rnd_sat(diff, 1'b0);
          end else begin
            vec_r[jstep[2:1]] <= 64'(diff);
          end
        end
      end
      S_DOT: begin
        if (step_r != 6'd0 && step_r <= 6'd9) begin
          if (ptag[1:0] == 2'd0) begin
            acc_r <= p_r;
          end else begin
            acc_r <= acc_r + p_r;
          end
          if (ptag[1:0] == 2'd2) begin
            dsum_r[ptag[3:2]] <= acc_r + p_r;
          end
        end
        if (step_r == 6'd10) begin
          d_r[0] <= rnd_sat(dsum_r[0], 1'b1);
          d_r[1] <= rnd_sat(dsum_r[1], 1'b1);
          d_r[2] <= rnd_sat(dsum_r[2], 1'b0);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    col.idx  = step_r[1:0];
    col.last = (step_r[1:0] == COL_LAST);
    unique case (step_r[1:0])
      2'd0: col.row = {32'sd0, -f_r[0], u_r[0], s_r[0]};
      2'd1: col.row = {32'sd0, -f_r[1], u_r[1], s_r[1]};
      2'd2: col.row = {32'sd0, -f_r[2], u_r[2], s_r[2]};
      default: col.row = {ONE_Q, d_r[2], d_r[1], d_r[0]};
    endcase
  end

endmodule

>>> rtl/lav_outq.sv
// ----------------------------------------------------------------------------
// lav_outq
// Result queue: four matrix columns between the engine and the result port.
// ----------------------------------------------------------------------------
module lav_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          col_push,
  output logic          col_full,
  input  lav_pkg::col_t col_in,
  output logic          out_empty,
  input  logic          out_pop,
  output lav_pkg::col_t col_out
);
  import lav_pkg::*;

  col_t       mem_r [4];
  logic [1:0] wr_r;
  logic [1:0] rd_r;
  logic [2:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign col_full  = (cnt_r == 3'd4);
  assign out_empty = (cnt_r == 3'd0);
  assign do_push   = col_push && !col_full;
  assign do_pop    = out_pop && !out_empty;
  assign col_out   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 2'd1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 2'd1;
      end
      cnt_r <= cnt_r + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule
